/* rtl/mlr_pkg.sv */
`timescale 1ns / 1ps
// Types, widths and octant codes for the midpoint line rasteriser.
// Stand-alone; every other file takes it in by wildcard import.
package mlr_pkg;

	localparam int COORD_BITS    = 12;
	localparam int COLOR_BITS    = 24;
	localparam int STEP_BITS     = COORD_BITS + 3;
	localparam int DEC_BITS      = COORD_BITS + 4;
	localparam int CHUNK_PIXELS  = 64;
	localparam int CHUNK_BITS    = $clog2(CHUNK_PIXELS);
	localparam int FIFO_DEPTH    = 2;
	localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		OCT_SHALLOW_RISE = 2'd0,
		OCT_STEEP_RISE   = 2'd1,
		OCT_STEEP_FALL   = 2'd2,
		OCT_SHALLOW_FALL = 2'd3
	} octant_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_DRAW = 1'b1
	} back_state_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic        [COLOR_BITS-1:0] line_color;
	} cmd_in_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pixel_x;
		logic signed [COORD_BITS-1:0] pixel_y;
		logic        [COLOR_BITS-1:0] pixel_color;
		logic                         last_pixel;
	} pixel_t;

	// Classified command as it waits in the queue.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] x0;
		logic signed [COORD_BITS-1:0] y0;
		logic signed [COORD_BITS-1:0] x1;
		logic signed [COORD_BITS-1:0] y1;
		logic signed [STEP_BITS-1:0]  step_a;
		logic signed [STEP_BITS-1:0]  step_b;
		logic signed [DEC_BITS-1:0]   decision;
		octant_t                      octant;
		logic        [COLOR_BITS-1:0] color;
	} line_cmd_t;

endpackage

/* rtl/mlr_front.sv */
`timescale 1ns / 1ps
// Front end: orders the endpoints and classifies the octant of one command.
// Depends on mlr_pkg.
module mlr_front import mlr_pkg::*; (
	input  cmd_in_t   cmd,
	output line_cmd_t cls
);

	logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
	logic signed [STEP_BITS-1:0]  diff_x, diff_y, step_a, step_b, neg_b;
	logic signed [DEC_BITS-1:0]   a_ext, b_ext, half_a, half_b;
	logic                         swap;

	always_comb begin
		swap = cmd.start_x > cmd.end_x;
		x0 = swap ? cmd.end_x   : cmd.start_x;
		y0 = swap ? cmd.end_y   : cmd.start_y;
		x1 = swap ? cmd.start_x : cmd.end_x;
		y1 = swap ? cmd.start_y : cmd.end_y;

		diff_x = STEP_BITS'(x1) - STEP_BITS'(x0);
		diff_y = STEP_BITS'(y1) - STEP_BITS'(y0);
		step_a = diff_y <<< 1;
		neg_b  = diff_x <<< 1;
		step_b = -neg_b;

		a_ext  = DEC_BITS'(step_a);
		b_ext  = DEC_BITS'(step_b);
		// steps are even, so halving is exact
		half_a = a_ext >>> 1;
		half_b = b_ext >>> 1;

		cls.x0     = x0;
		cls.y0     = y0;
		cls.x1     = x1;
		cls.y1     = y1;
		cls.step_a = step_a;
		cls.step_b = step_b;
		cls.color  = cmd.line_color;

		if (!step_a[STEP_BITS-1] && (step_a <= neg_b)) begin
			cls.octant   = OCT_SHALLOW_RISE;
			cls.decision = a_ext + half_b;
		end else if (!step_a[STEP_BITS-1]) begin
			cls.octant   = OCT_STEEP_RISE;
			cls.decision = half_a + b_ext;
		end else if (step_a <= step_b) begin
			cls.octant   = OCT_STEEP_FALL;
			cls.decision = half_a - b_ext;
		end else begin
			cls.octant   = OCT_SHALLOW_FALL;
			cls.decision = a_ext - half_b;
		end
	end

endmodule

/* rtl/mlr_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front end and the stepper.
// Depends on mlr_pkg.
module mlr_queue import mlr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  line_cmd_t  wr_data,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output line_cmd_t  rd_data
);

	line_cmd_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0]  count_q;
	logic                      do_push, do_pop;

	assign full      = (count_q == FIFO_CNT_BITS'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	function automatic logic [FIFO_PTR_BITS-1:0] next_ptr(input logic [FIFO_PTR_BITS-1:0] p);
		next_ptr = (p == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/mlr_stepper.sv */
`timescale 1ns / 1ps
// Back end: midpoint stepper and pixel output register.
// Depends on mlr_pkg; fed by mlr_queue.
module mlr_stepper import mlr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  line_cmd_t  cmd,
	input  logic       cmd_avail,
	output logic       cmd_pop,
	output logic       pix_valid,
	input  logic       pix_ready,
	output pixel_t     pix
);

	back_state_t                  state_q, state_d;
	logic                         line_busy_q;
	logic [CHUNK_BITS-1:0]        cnt_q;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, stop_x_q, stop_y_q;
	logic signed [STEP_BITS-1:0]  step_a_q, step_b_q;
	logic signed [DEC_BITS-1:0]   dec_q;
	octant_t                      oct_q;
	logic        [COLOR_BITS-1:0] color_q;
	logic                         pix_valid_q;
	pixel_t                       pix_q;

	logic                         pop, slot_free, emit, last;
	logic                         dec_pos, dec_neg;
	logic signed [DEC_BITS-1:0]   a_ext, b_ext, nd;
	logic signed [COORD_BITS-1:0] nx, ny;

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;
	assign slot_free = !pix_valid_q || pix_ready;
	assign cmd_pop   = pop;

	// next state and queue pop
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_avail) begin
					pop     = 1'b1;
					state_d = BK_DRAW;
				end
			end
			BK_DRAW: begin
				if (slot_free) begin
					emit = 1'b1;
					if (last || (cnt_q == CHUNK_BITS'(CHUNK_PIXELS - 1))) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// one midpoint step; ties keep the straight step
	always_comb begin
		a_ext   = DEC_BITS'(step_a_q);
		b_ext   = DEC_BITS'(step_b_q);
		dec_neg = dec_q[DEC_BITS-1];
		dec_pos = !dec_neg && (dec_q != '0);
		nx      = cur_x_q;
		ny      = cur_y_q;
		nd      = dec_q;
		case (oct_q)
			OCT_SHALLOW_RISE: begin
				last = (cur_x_q == stop_x_q);
				if (dec_pos) begin
					ny = cur_y_q + COORD_BITS'(1);
					nd = nd + b_ext;
				end
				nx = cur_x_q + COORD_BITS'(1);
				nd = nd + a_ext;
			end
			OCT_STEEP_RISE: begin
				last = (cur_y_q == stop_y_q);
				if (dec_neg) begin
					nx = cur_x_q + COORD_BITS'(1);
					nd = nd + a_ext;
				end
				ny = cur_y_q + COORD_BITS'(1);
				nd = nd + b_ext;
			end
			OCT_STEEP_FALL: begin
				last = (cur_y_q == stop_y_q);
				if (dec_pos) begin
					nx = cur_x_q + COORD_BITS'(1);
					nd = nd + a_ext;
				end
				ny = cur_y_q - COORD_BITS'(1);
				nd = nd - b_ext;
			end
			default: begin
				last = (cur_x_q == stop_x_q);
				if (dec_neg) begin
					ny = cur_y_q - COORD_BITS'(1);
					nd = nd - b_ext;
				end
				nx = cur_x_q + COORD_BITS'(1);
				nd = nd + a_ext;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			line_busy_q <= 1'b0;
			cnt_q       <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				cnt_q <= '0;
				line_busy_q <= 1'b1;
			end else if (emit) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					line_busy_q <= 1'b0;
				end
			end
			if (emit) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		// a beat popped while a line is open only grants the next chunk
		if (pop && !line_busy_q) begin
			cur_x_q  <= cmd.x0;
			cur_y_q  <= cmd.y0;
			stop_x_q <= cmd.x1;
			stop_y_q <= cmd.y1;
			step_a_q <= cmd.step_a;
			step_b_q <= cmd.step_b;
			dec_q    <= cmd.decision;
			oct_q    <= cmd.octant;
			color_q  <= cmd.color;
		end else if (emit && !last) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			dec_q   <= nd;
		end
		if (emit) begin
			pix_q.pixel_x     <= cur_x_q;
			pix_q.pixel_y     <= cur_y_q;
			pix_q.pixel_color <= color_q;
			pix_q.last_pixel  <= last;
		end
	end

endmodule

/* rtl/midpoint_line_rasterizer.sv */
`timescale 1ns / 1ps
// Top level of the midpoint line rasteriser: front end, command queue, stepper.
// Depends on mlr_pkg, mlr_front, mlr_queue and mlr_stepper.
//
//   channel  | handshake            | payload          | beat carries
//   ---------+----------------------+------------------+---------------------------
//   command  | cmd_valid, cmd_ready | cmd (cmd_in_t)   | two endpoints and a colour
//   pixel    | pix_valid, pix_ready | pix (pixel_t)    | one pixel, colour, last flag
//
// One command beat grants a chunk of up to 64 pixel beats, one per cycle while
// pix_ready holds high; the stepper pops the queue from its idle state before
// each chunk, so a line of N pixels takes ceil(N/64) command beats.
// A command beat that arrives while a line is still open only releases the
// next chunk of that line; its payload is dropped.
// Reset (arst_n low) empties the queue and closes any open line at once.
// A stalled pixel beat holds the stepper; the two-entry queue keeps taking
// command beats until it is full.
module midpoint_line_rasterizer import mlr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  cmd_in_t cmd,
	output logic    pix_valid,
	input  logic    pix_ready,
	output pixel_t  pix
);

	line_cmd_t  cls;
	line_cmd_t  head;
	logic       q_full;
	logic       q_avail;
	logic       q_pop;

	// classify on the way in, so the queue holds ready-to-run commands
	mlr_front u_front (
		.cmd (cmd),
		.cls (cls)
	);

	assign cmd_ready = !q_full;

	mlr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid),
		.wr_data   (cls),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_avail),
		.rd_data   (head)
	);

	// step the line and hold each pixel in the output register
	mlr_stepper u_stepper (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head),
		.cmd_avail (q_avail),
		.cmd_pop   (q_pop),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

endmodule

/* rtl/mlr_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the midpoint line rasteriser, bound to the top level.
// Depends on mlr_pkg.
module mlr_checker import mlr_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    cmd_valid,
	input logic    cmd_ready,
	input logic    pix_valid,
	input logic    pix_ready,
	input pixel_t  pix
);

	logic                         seen_cmd_q;
	logic                         open_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic        [COLOR_BITS-1:0] prev_color_q;
	logic signed [COORD_BITS:0]   dx, dy;
	logic                         pix_beat;

	assign pix_beat = pix_valid && pix_ready;
	assign dx = (COORD_BITS + 1)'(pix.pixel_x) - (COORD_BITS + 1)'(prev_x_q);
	assign dy = (COORD_BITS + 1)'(pix.pixel_y) - (COORD_BITS + 1)'(prev_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_cmd_q   <= 1'b0;
			open_q       <= 1'b0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_color_q <= '0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				seen_cmd_q <= 1'b1;
			end
			if (pix_beat) begin
				open_q       <= !pix.last_pixel;
				prev_x_q     <= pix.pixel_x;
				prev_y_q     <= pix.pixel_y;
				prev_color_q <= pix.pixel_color;
			end
		end
	end

	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("pixel beat changed while stalled");

	a_no_pix_before_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> seen_cmd_q)
		else $error("pixel shown before any command beat");

	a_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		pix_beat && open_q |->
			(dx == 0 || dx == 1) && (dy == 0 || dy == 1 || dy == -1) &&
			!(dx == 0 && dy == 0))
		else $error("consecutive pixels of a line are not neighbours");

	a_colour_held: assert property (@(posedge clk) disable iff (!arst_n)
		pix_beat && open_q |-> pix.pixel_color == prev_color_q)
		else $error("colour changed inside a line");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for midpoint_line_rasterizer: line commands in, pixel beats out.
// Depends on mlr_pkg and the rasteriser RTL; every pixel beat is checked in order.
module tb_top;
	import mlr_pkg::*;

	localparam int NUM_PROBES   = 24;
	localparam int RANDOM_LINES = 40;
	localparam int CALM_TAIL    = 10;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
	localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;

	// One row of the directed table. Where typed is set, the single pixel that the
	// command draws is written out in ex, ey and ecolor; its last flag is always 1.
	typedef struct packed {
		int          x0;
		int          y0;
		int          x1;
		int          y1;
		int unsigned color;
		bit          typed;
		int          ex;
		int          ey;
		int unsigned ecolor;
	} probe_t;

	probe_t probes [NUM_PROBES] = '{
		// single points at the origin and at the corners of the coordinate range
		'{0, 0, 0, 0, 'h000000, 1'b1, 0, 0, 'h000000},
		'{-2048, -2048, -2048, -2048, 'hFFFFFF, 1'b1, -2048, -2048, 'hFFFFFF},
		'{2047, 2047, 2047, 2047, 'h000000, 1'b1, 2047, 2047, 'h000000},
		'{2047, -2048, 2047, -2048, 'hA5A5A5, 1'b1, 2047, -2048, 'hA5A5A5},
		'{-2048, 2047, -2048, 2047, 'h5A5A5A, 1'b1, -2048, 2047, 'h5A5A5A},
		// horizontal and vertical, both directions (the leftward one is swapped)
		'{-5, 3, 5, 3, 'h123456, 1'b0, 0, 0, 0},
		'{5, 3, -5, 3, 'h654321, 1'b0, 0, 0, 0},
		'{2, -4, 2, 4, 'h00FF00, 1'b0, 0, 0, 0},
		'{2, 4, 2, -4, 'h0000FF, 1'b0, 0, 0, 0},
		// exact diagonals
		'{0, 0, 7, 7, 'hFF0000, 1'b0, 0, 0, 0},
		'{0, 0, 7, -7, 'h800000, 1'b0, 0, 0, 0},
		// one line in each octant pair, then two with swapped endpoints
		'{0, 0, 10, 3, 'h010203, 1'b0, 0, 0, 0},
		'{0, 0, 3, 10, 'h0A0B0C, 1'b0, 0, 0, 0},
		'{0, 0, 3, -10, 'hC0FFEE, 1'b0, 0, 0, 0},
		'{0, 0, 10, -3, 'hBEEF00, 1'b0, 0, 0, 0},
		'{3, 10, 0, 0, 'h777777, 1'b0, 0, 0, 0},
		'{10, 0, 0, 3, 'h888888, 1'b0, 0, 0, 0},
		// decision starts at zero: the tie must keep the straight step
		'{0, 0, 4, 2, 'h111111, 1'b0, 0, 0, 0},
		'{0, 0, 2, 4, 'h222222, 1'b0, 0, 0, 0},
		'{0, 0, 2, -4, 'h333333, 1'b0, 0, 0, 0},
		'{0, 0, 4, -2, 'h444444, 1'b0, 0, 0, 0},
		// exactly one chunk, then one pixel over
		'{0, 0, 63, 0, 'h00AA55, 1'b0, 0, 0, 0},
		'{0, 0, 64, 5, 'h55AA00, 1'b0, 0, 0, 0},
		// full-range diagonal: sixty-four command beats
		'{-2048, -2048, 2047, 2047, 'h000000, 1'b0, 0, 0, 0}
	};

	logic    clk;
	logic    arst_n;
	logic    cmd_valid;
	logic    cmd_ready;
	cmd_in_t cmd;
	logic    pix_valid;
	logic    pix_ready = 1'b0;
	pixel_t  pix;

	midpoint_line_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Predicted pen state: a copy of what the stepper should hold between beats.
	int                    trace_x, trace_y, goal_x, goal_y;
	int                    err_term, rise_step, run_step;
	octant_t               trace_oct;
	logic [COLOR_BITS-1:0] trace_color;
	bit                    line_open;
	pixel_t                pending_pixels [$];

	int     errors = 0;
	int     lines = 0;
	int     beats = 0;
	int     pixels_checked = 0;
	int     cycles = 0;
	int     ready_hold = 0;
	bit     calm = 1'b0;
	pixel_t due_pixel;

	// Work out the pixels that one command beat releases. An idle pen loads the
	// command; an open line ignores the payload and carries on for one more chunk.
	function automatic void plot_chunk(input cmd_in_t c, input bit keep);
		int     x0, y0, x1, y1, n, t;
		bit     fin;
		pixel_t p;
		if (!line_open) begin
			x0 = int'(c.start_x);
			y0 = int'(c.start_y);
			x1 = int'(c.end_x);
			y1 = int'(c.end_y);
			// order the endpoints so that x never decreases
			if (x0 > x1) begin
				t = x0; x0 = x1; x1 = t;
				t = y0; y0 = y1; y1 = t;
			end
			rise_step = 2 * (y1 - y0);
			run_step  = -2 * (x1 - x0);
			if (rise_step >= 0 && rise_step <= -run_step) begin
				trace_oct = OCT_SHALLOW_RISE;
				err_term  = rise_step + run_step / 2;
			end else if (rise_step >= 0) begin
				trace_oct = OCT_STEEP_RISE;
				err_term  = rise_step / 2 + run_step;
			end else if (rise_step <= run_step) begin
				trace_oct = OCT_STEEP_FALL;
				err_term  = rise_step / 2 - run_step;
			end else begin
				trace_oct = OCT_SHALLOW_FALL;
				err_term  = rise_step - run_step / 2;
			end
			trace_x     = x0;
			trace_y     = y0;
			goal_x      = x1;
			goal_y      = y1;
			trace_color = c.line_color;
			line_open   = 1'b1;
		end
		n = 0;
		while (line_open && n < CHUNK_PIXELS) begin
			// shallow lines end on x, steep ones on y
			if (trace_oct == OCT_SHALLOW_RISE || trace_oct == OCT_SHALLOW_FALL)
				fin = (trace_x == goal_x);
			else
				fin = (trace_y == goal_y);
			p.pixel_x     = COORD_BITS'(trace_x);
			p.pixel_y     = COORD_BITS'(trace_y);
			p.pixel_color = trace_color;
			p.last_pixel  = fin;
			if (keep)
				pending_pixels.push_back(p);
			n++;
			if (fin)
				line_open = 1'b0;
			else begin
				case (trace_oct)
					OCT_SHALLOW_RISE: begin
						if (err_term > 0) begin
							trace_y++;
							err_term += run_step;
						end
						trace_x++;
						err_term += rise_step;
					end
					OCT_STEEP_RISE: begin
						if (err_term < 0) begin
							trace_x++;
							err_term += rise_step;
						end
						trace_y++;
						err_term += run_step;
					end
					OCT_STEEP_FALL: begin
						if (err_term > 0) begin
							trace_x++;
							err_term += rise_step;
						end
						trace_y--;
						err_term -= run_step;
					end
					default: begin
						if (err_term < 0) begin
							trace_y--;
							err_term -= run_step;
						end
						trace_x++;
						err_term += rise_step;
					end
				endcase
			end
		end
	endfunction

	function automatic int clamp_coord(input int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// Mostly short lines anywhere on the grid and, unless it comes out as a point, every
	// eighth one medium, so the run stays short while every octant and several lengths turn up.
	function automatic cmd_in_t random_line(input int idx);
		int      span, x0, y0, x1, y1;
		cmd_in_t c;
		x0 = int'($urandom_range(0, 4095)) - 2048;
		y0 = int'($urandom_range(0, 4095)) - 2048;
		if ($urandom_range(0, 9) == 0) begin
			x1 = x0;
			y1 = y0;
		end else begin
			span = (idx % 8 == 7) ? 300 : 16;
			x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
			y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
		end
		c.start_x    = COORD_BITS'(x0);
		c.start_y    = COORD_BITS'(y0);
		c.end_x      = COORD_BITS'(x1);
		c.end_y      = COORD_BITS'(y1);
		c.line_color = COLOR_BITS'($urandom);
		return c;
	endfunction

	// Present one command beat and hold it until it is taken. A random gap may
	// come first; valid is only ever assigned once per edge.
	task automatic issue_beat(input cmd_in_t c);
		if (!calm && $urandom_range(0, 2) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		beats++;
	endtask

	// Send one line, then random filler beats until the predicted pen closes it:
	// each filler beat releases the next chunk and its payload must be ignored.
	task automatic send_line(input cmd_in_t c, input bit keep);
		cmd_in_t filler;
		issue_beat(c);
		plot_chunk(c, keep);
		lines++;
		while (line_open) begin
			filler = {$urandom, $urandom, 8'($urandom)};
			issue_beat(filler);
			plot_chunk(filler, 1'b1);
		end
	endtask

	// Pixel side: alternate ready stretches with stall bursts of random length,
	// and hold ready high once the tail of the run is reached.
	always @(posedge clk) begin
		if (arst_n) begin
			if (calm)
				pix_ready <= 1'b1;
			else if (ready_hold != 0)
				ready_hold <= ready_hold - 1;
			else if (pix_ready) begin
				pix_ready  <= 1'b0;
				ready_hold <= $urandom_range(0, 14);
			end else begin
				pix_ready  <= 1'b1;
				ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				                                          : $urandom_range(0, 20);
			end
		end
	end

	// Check every accepted pixel beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pix_valid && pix_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t ns: pixel beat with nothing expected: x=%0d y=%0d colour=%h last=%b",
				         $time, pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last_pixel);
				errors++;
			end else begin
				due_pixel = pending_pixels.pop_front();
				pixels_checked++;
				if (pix.pixel_x !== due_pixel.pixel_x || pix.pixel_y !== due_pixel.pixel_y ||
				    pix.pixel_color !== due_pixel.pixel_color ||
				    pix.last_pixel !== due_pixel.last_pixel) begin
					$display("%0t ns: pixel mismatch: expected x=%0d y=%0d colour=%h last=%b",
					         $time, due_pixel.pixel_x, due_pixel.pixel_y,
					         due_pixel.pixel_color, due_pixel.last_pixel);
					$display("%0t ns:                 actual   x=%0d y=%0d colour=%h last=%b",
					         $time, pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last_pixel);
					errors++;
				end
			end
		end
	end

	// Watchdog: far beyond the slowest legal run, including full stalls on every beat.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t ns: timed out with %0d pixel beats outstanding",
			         $time, pending_pixels.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int      k;
		cmd_in_t c;
		pixel_t  typed_px;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		line_open = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: typed rows carry their own single pixel; the rest go
		// through the predictor.
		for (k = 0; k < NUM_PROBES; k++) begin
			c.start_x    = COORD_BITS'(probes[k].x0);
			c.start_y    = COORD_BITS'(probes[k].y0);
			c.end_x      = COORD_BITS'(probes[k].x1);
			c.end_y      = COORD_BITS'(probes[k].y1);
			c.line_color = COLOR_BITS'(probes[k].color);
			send_line(c, !probes[k].typed);
			if (probes[k].typed) begin
				typed_px.pixel_x     = COORD_BITS'(probes[k].ex);
				typed_px.pixel_y     = COORD_BITS'(probes[k].ey);
				typed_px.pixel_color = COLOR_BITS'(probes[k].ecolor);
				typed_px.last_pixel  = 1'b1;
				pending_pixels.push_back(typed_px);
			end
		end

		// Random lines; drop all idling for the final stretch.
		for (k = 0; k < RANDOM_LINES; k++) begin
			if (k == RANDOM_LINES - CALM_TAIL)
				calm <= 1'b1;
			send_line(random_line(k), 1'b1);
		end
		cmd_valid <= 1'b0;

		// Drain, then leave room for any stray beat to show up.
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drew %0d lines over %0d command beats, all four octant pairs and a full-range span.",
		         lines, beats);
		$display("Compared %0d pixel beats under random stalls on both channels.", pixels_checked);
		if (errors == 0 && pending_pixels.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
rtl/mlr_pkg.sv
rtl/mlr_front.sv
rtl/mlr_queue.sv
rtl/mlr_stepper.sv
rtl/midpoint_line_rasterizer.sv
rtl/mlr_checker.sv
sim/tb_top.sv
